@@ rtl/core/bsi_pkg.sv @@
// ----------------------------------------------------------------------------
// bsi_pkg
// Shared types, codes and saturation helper for the boid steering integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsi_pkg;

	// default number of fraction bits
	localparam int FRAC_BITS_DEF = 16;

	// action codes
	typedef logic [2:0] act_t;
	localparam act_t ACT_SEEK       = 3'd0;
	localparam act_t ACT_SEEK_RANGE = 3'd1;
	localparam act_t ACT_ARRIVE     = 3'd2;
	localparam act_t ACT_FLEE       = 3'd3;
	localparam act_t ACT_BRAKE      = 3'd4;
	localparam act_t ACT_TICK       = 3'd5;

	// register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_MAX_SPEED = 2'd0;
	localparam reg_idx_t REG_MAX_FORCE = 2'd1;
	localparam reg_idx_t REG_NEAR_SQ   = 2'd2;

	// register reset values
	localparam logic [30:0] MAX_SPEED_RST = 31'd262144;
	localparam logic [30:0] MAX_FORCE_RST = 31'd6554;
	localparam logic [30:0] NEAR_SQ_RST   = 31'd66;

	// clamp a wide signed value to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (x > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (x < lo) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsi_mul.sv @@
// ----------------------------------------------------------------------------
// bsi_mul
// Shared 33x33 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsi_mul import bsi_pkg::*; (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] prod
);

	logic signed [65:0] prod_q;

	// one product per cycle, available the cycle after the operands
	always_ff @(posedge clk) begin
		prod_q <= 66'(a) * 66'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

@@ rtl/core/bsi_div.sv @@
// ----------------------------------------------------------------------------
// bsi_div
// Restoring divider, one quotient bit per cycle, truncates towards zero.
// The quotient magnitude must stay below 2^31.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsi_div import bsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic        [31:0] divisor,
	output logic               done,
	output logic signed [31:0] quo
);

	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic        neg_q;
	logic [31:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] dvs_q;
	logic [63:0] mag;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	// magnitude of the dividend and the trial subtract
	always_comb begin
		mag   = dividend[63] ? 64'(-dividend) : 64'(dividend);
		trial = {rem_q, low_q[31]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			rem_q  <= '0;
			low_q  <= '0;
			dvs_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= dividend[63];
			rem_q  <= mag[63:32];
			low_q  <= mag[31:0];
			dvs_q  <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			low_q <= {low_q[30:0], ge};
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(low_q) : $signed(low_q);

endmodule

`default_nettype wire

@@ rtl/core/bsi_sqrt.sv @@
// ----------------------------------------------------------------------------
// bsi_sqrt
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsi_sqrt import bsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic        run_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] rb;
	logic        ge;

	always_comb begin
		rb = r_q + bit_q;
		ge = v_q >= rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			v_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			v_q    <= radicand;
			r_q    <= '0;
			bit_q  <= {2'b01, 62'b0};
		end else if (run_q) begin
			if (ge) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
			// last step works on the lowest bit
			if (bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign root = r_q[31:0];

endmodule

`default_nettype wire

@@ rtl/core/boid_steering_integrator_core.sv @@
// ----------------------------------------------------------------------------
// boid_steering_integrator_core
// One agent's 3D steering and integration unit in signed fixed point.
//
//   channel  direction  handshake             word
//   cfg      in         cfg_we                cfg_idx, cfg_wdata
//   in       in         in_valid / in_stall   action, target_*, range_dist,
//                                             gain, brake_amount
//   out      out        out_valid / out_stall pos_*, vel_*, force_added
//
// One word at a time runs through a sequencer around one shared multiplier,
// one bit-serial divider and one square root unit. A tick adds a square root
// and a division when the speed is capped; a steering action ends early on a
// range miss and at most runs a square root and a division for both the
// desired and the capped vector.
// in_stall is high from acceptance until the result is in the output register;
// a result waiting on out_stall does not block the next word.
// arst_n clears state to zero and the registers to their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boid_steering_integrator_core import bsi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_idx,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic [30:0]        range_dist,
	input  logic signed [31:0] gain,
	input  logic [16:0]        brake_amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic signed [31:0] vel_z,
	output logic               force_added
);

	localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

	typedef enum logic [17:0] {
		S_IDLE      = 18'h00001,
		S_START     = 18'h00002,
		S_SQ_MUL    = 18'h00004,
		S_SQ_ACC    = 18'h00008,
		S_K_MUL     = 18'h00010,
		S_K_WB      = 18'h00020,
		S_SQRT_GO   = 18'h00040,
		S_SQRT_WAIT = 18'h00080,
		S_SC_MUL    = 18'h00100,
		S_SC_DIV    = 18'h00200,
		S_DIV_WAIT  = 18'h00400,
		S_SUBV      = 18'h00800,
		S_GN_MUL    = 18'h01000,
		S_GN_WB     = 18'h02000,
		S_BRK_MUL   = 18'h04000,
		S_BRK_WB    = 18'h08000,
		S_TKUPD     = 18'h10000,
		S_DONE      = 18'h20000
	} state_t;

	// which sub-sequence the shared steps serve
	typedef enum logic [2:0] {
		PH_TICK = 3'b001,
		PH_DES  = 3'b010,
		PH_CAP  = 3'b100
	} phase_t;

	state_t state_q;
	phase_t ph_q;
	logic [1:0] c_q;

	logic [30:0] spd_q;
	logic [30:0] frc_q;
	logic [30:0] thr_q;

	logic signed [31:0] pos_q[3];
	logic signed [31:0] vel_q[3];
	logic signed [31:0] acc_q[3];
	logic signed [31:0] vec_q[3];
	logic signed [31:0] tgt_q[3];
	act_t               act_q;
	logic [30:0]        rng_q;
	logic signed [31:0] gain_q;
	logic [16:0]        brk_q;
	logic [63:0]        sum_q;
	logic [31:0]        dvs_q;
	logic               add_q;

	logic signed [31:0] opos_q[3];
	logic signed [31:0] ovel_q[3];
	logic               oforce_q;
	logic               ovalid_q;

	// shared units
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod;
	logic               div_done;
	logic signed [31:0] div_quo;
	logic               sq_done;
	logic [31:0]        sq_root;

	bsi_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	bsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SC_DIV),
		.dividend (prod[63:0]),
		.divisor  (dvs_q),
		.done     (div_done),
		.quo      (div_quo)
	);

	bsi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SQRT_GO),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	// datapath helpers
	logic [30:0]        k_op;
	logic [30:0]        scale_op;
	logic [31:0]        brk_c;
	logic [31:0]        bf;
	logic signed [31:0] mulq_val;
	logic signed [31:0] gn_f;
	logic signed [31:0] acc_new;
	logic [63:0]        ksq;
	logic               near;
	logic               rng_big;
	logic               range_pass;
	logic               ease_ok;
	logic               out_load;

	// finished word moves into a free or draining output register
	assign out_load = (state_q == S_DONE) && (!ovalid_q || !out_stall);

	always_comb begin
		unique case (ph_q)
			PH_TICK: k_op = spd_q;
			PH_DES:  k_op = rng_q;
			PH_CAP:  k_op = frc_q;
			default: k_op = spd_q;
		endcase
		scale_op = (ph_q == PH_CAP) ? frc_q : spd_q;
		brk_c    = (32'(brk_q) > ONE_Q) ? ONE_Q : 32'(brk_q);
		bf       = ONE_Q - brk_c;
		mulq_val = sat32(prod >>> FRAC_BITS);
		gn_f     = (act_q == ACT_FLEE) ? sat32(-66'(mulq_val)) : mulq_val;
		acc_new  = sat32(66'(acc_q[c_q]) + 66'(gn_f));
		ksq      = prod[63:0];
		near     = sum_q <= (64'(thr_q) << FRAC_BITS);
		rng_big  = 32'(rng_q) > ONE_Q;
		unique case (act_q)
			ACT_SEEK_RANGE: range_pass = !(sum_q < ksq);
			ACT_FLEE:       range_pass = !(sum_q > ksq);
			default:        range_pass = 1'b1;
		endcase
		ease_ok = ((act_q == ACT_ARRIVE) || (act_q == ACT_FLEE)) && rng_big && (sum_q < ksq);
	end

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = 33'(vec_q[c_q]);
				mul_b = 33'(vec_q[c_q]);
			end
			S_K_MUL: begin
				mul_a = $signed({2'b00, k_op});
				mul_b = $signed({2'b00, k_op});
			end
			S_SC_MUL: begin
				mul_a = 33'(vec_q[c_q]);
				mul_b = $signed({2'b00, scale_op});
			end
			S_GN_MUL: begin
				mul_a = 33'(vec_q[c_q]);
				mul_b = 33'(gain_q);
			end
			S_BRK_MUL: begin
				mul_a = 33'(vel_q[c_q]);
				mul_b = $signed({1'b0, bf});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH_DES;
			c_q      <= '0;
			spd_q    <= MAX_SPEED_RST;
			frc_q    <= MAX_FORCE_RST;
			thr_q    <= NEAR_SQ_RST;
			act_q    <= ACT_SEEK;
			rng_q    <= '0;
			gain_q   <= '0;
			brk_q    <= '0;
			sum_q    <= '0;
			dvs_q    <= '0;
			add_q    <= 1'b0;
			oforce_q <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i]  <= '0;
				vel_q[i]  <= '0;
				acc_q[i]  <= '0;
				vec_q[i]  <= '0;
				tgt_q[i]  <= '0;
				opos_q[i] <= '0;
				ovel_q[i] <= '0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_MAX_SPEED: spd_q <= cfg_wdata;
					REG_MAX_FORCE: frc_q <= cfg_wdata;
					REG_NEAR_SQ:   thr_q <= cfg_wdata;
					default:       ;
				endcase
			end

			// output register valid: loaded, or word taken
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q    <= action;
						tgt_q[0] <= target_x;
						tgt_q[1] <= target_y;
						tgt_q[2] <= target_z;
						rng_q    <= range_dist;
						gain_q   <= gain;
						brk_q    <= brake_amount;
						state_q  <= S_START;
					end
				end
				S_START: begin
					add_q <= 1'b0;
					c_q   <= '0;
					if (act_q == ACT_SEEK || act_q == ACT_SEEK_RANGE ||
					    act_q == ACT_ARRIVE || act_q == ACT_FLEE) begin
						// target offset
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= sat32(66'(tgt_q[i]) - 66'(pos_q[i]));
						end
						ph_q    <= PH_DES;
						state_q <= S_SQ_MUL;
					end else if (act_q == ACT_TICK) begin
						for (int i = 0; i < 3; i++) begin
							vec_q[i] <= sat32(66'(vel_q[i]) + 66'(acc_q[i]));
						end
						ph_q    <= PH_TICK;
						state_q <= S_SQ_MUL;
					end else if (act_q == ACT_BRAKE) begin
						state_q <= S_BRK_MUL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SQ_MUL: begin
					state_q <= S_SQ_ACC;
				end
				S_SQ_ACC: begin
					// squared length, one component per pass
					sum_q <= ((c_q == 2'd0) ? 64'd0 : sum_q) + prod[63:0];
					if (c_q == 2'd2) begin
						c_q     <= '0;
						state_q <= S_K_MUL;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_K_MUL: begin
					state_q <= S_K_WB;
				end
				S_K_WB: begin
					unique case (ph_q)
						PH_TICK: begin
							if (sum_q >= ksq && sum_q != 64'd0) begin
								state_q <= S_SQRT_GO;
							end else begin
								state_q <= S_TKUPD;
							end
						end
						PH_DES: begin
							if (!range_pass) begin
								state_q <= S_DONE;
							end else begin
								add_q <= 1'b1;
								if (near) begin
									state_q <= S_GN_MUL;
								end else if (ease_ok) begin
									dvs_q   <= 32'(rng_q);
									state_q <= S_SC_MUL;
								end else begin
									state_q <= S_SQRT_GO;
								end
							end
						end
						PH_CAP: begin
							if (sum_q > ksq) begin
								state_q <= S_SQRT_GO;
							end else begin
								state_q <= S_GN_MUL;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SQRT_GO: begin
					state_q <= S_SQRT_WAIT;
				end
				S_SQRT_WAIT: begin
					if (sq_done) begin
						dvs_q   <= sq_root;
						c_q     <= '0;
						state_q <= S_SC_MUL;
					end
				end
				S_SC_MUL: begin
					state_q <= S_SC_DIV;
				end
				S_SC_DIV: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						vec_q[c_q] <= div_quo;
						if (c_q == 2'd2) begin
							c_q <= '0;
							unique case (ph_q)
								PH_TICK: state_q <= S_TKUPD;
								PH_DES:  state_q <= S_SUBV;
								PH_CAP:  state_q <= S_GN_MUL;
								default: state_q <= S_DONE;
							endcase
						end else begin
							c_q     <= c_q + 2'd1;
							state_q <= S_SC_MUL;
						end
					end
				end
				S_SUBV: begin
					// desired minus current velocity
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= sat32(66'(vec_q[i]) - 66'(vel_q[i]));
					end
					ph_q    <= PH_CAP;
					c_q     <= '0;
					state_q <= S_SQ_MUL;
				end
				S_GN_MUL: begin
					state_q <= S_GN_WB;
				end
				S_GN_WB: begin
					acc_q[c_q] <= acc_new;
					if (c_q == 2'd2) begin
						c_q     <= '0;
						state_q <= S_DONE;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_GN_MUL;
					end
				end
				S_BRK_MUL: begin
					state_q <= S_BRK_WB;
				end
				S_BRK_WB: begin
					vel_q[c_q] <= mulq_val;
					if (c_q == 2'd2) begin
						c_q     <= '0;
						state_q <= S_DONE;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= S_BRK_MUL;
					end
				end
				S_TKUPD: begin
					for (int i = 0; i < 3; i++) begin
						vel_q[i] <= vec_q[i];
						pos_q[i] <= sat32(66'(pos_q[i]) + 66'(vec_q[i]));
						acc_q[i] <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hand over once the output register is free
					if (out_load) begin
						for (int i = 0; i < 3; i++) begin
							opos_q[i] <= pos_q[i];
							ovel_q[i] <= vel_q[i];
						end
						oforce_q <= add_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = ovalid_q;
	assign pos_x       = opos_q[0];
	assign pos_y       = opos_q[1];
	assign pos_z       = opos_q[2];
	assign vel_x       = ovel_q[0];
	assign vel_y       = ovel_q[1];
	assign vel_z       = ovel_q[2];
	assign force_added = oforce_q;

endmodule

`default_nettype wire
